@@ sv/hcb_pkg.sv @@
`default_nettype none
package hcb_pkg;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic merge_a;
    logic merge_b;
    logic walk_init;
    logic wlatch;
    logic walk_up;
    logic next_sym;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic merge_pend;
    logic taken_c;
    logic last_sym;
  } sts_t;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;

endpackage
`default_nettype wire

@@ sv/hcb_ram.sv @@
`default_nettype none
module hcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ sv/hcb_datapath.sv @@
`default_nettype none
module hcb_datapath #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hcb_pkg::cmd_t cmd,
  output hcb_pkg::sts_t      sts,
  input  wire logic [15:0]   in_weight,
  output logic [3:0]         sym_index,
  output logic [15:0]        sym_weight,
  output logic [14:0]        code_bits,
  output logic [3:0]         code_len
);

  localparam int unsigned NODE_N = 2 * MAX_SYMBOLS;
  localparam int unsigned NW     = $clog2(NODE_N);
  localparam int unsigned CW     = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned KW     = $clog2(MAX_SYMBOLS);
  localparam int unsigned SUM_W  = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
  localparam int unsigned LW     = NW + 1;

  logic [CW-1:0]     leaf_r, leaf_nxt;
  logic [NW-1:0]     next_r, next_nxt;
  logic [NW-1:0]     i_r, i_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [NW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              f1_r, f1_nxt, f2_r, f2_nxt;
  logic [SUM_W-1:0]  w1_r, w1_nxt, w2_r, w2_nxt;
  logic [NW-1:0]     a_r, a_nxt, b_r, b_nxt;
  logic [NODE_N-1:0] taken_r, taken_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [NW-1:0]     c_r, c_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [14:0]       code_r, code_nxt;
  logic [SUM_W-1:0]  symw_r, symw_nxt;

  logic              w_we;
  logic [NW-1:0]     w_waddr, w_raddr;
  logic [SUM_W-1:0]  w_wdata, w_rdata;
  logic              p_we;
  logic [NW-1:0]     p_waddr;
  logic [NW:0]       p_wdata, p_rdata;

  logic [WEIGHT_BITS+15:0] in_ext;
  logic [SUM_W-1:0]        leaf_w;
  logic [SUM_W+15:0]       symw_ext;
  logic [KW+3:0]           k_ext;
  logic [KW-1:0]           k_inc;

  assign in_ext = {{WEIGHT_BITS{1'b0}}, in_weight};
  assign leaf_w = {{(SUM_W - WEIGHT_BITS){1'b0}}, in_ext[WEIGHT_BITS-1:0]};
  assign k_inc  = k_r + KW'(1);

  hcb_ram #(.WIDTH(SUM_W), .DEPTH(NODE_N)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  hcb_ram #(.WIDTH(NW + 1), .DEPTH(NODE_N)) u_pram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(c_r), .rdata(p_rdata)
  );

  always_comb begin
    w_raddr = i_r;
    if (cmd.walk_init) begin
      w_raddr = NW'(k_r);
    end else if (cmd.next_sym) begin
      w_raddr = NW'(k_inc);
    end
  end

  always_comb begin
    leaf_nxt   = leaf_r;
    next_nxt   = next_r;
    i_nxt      = i_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = i_r;
    f1_nxt     = f1_r;
    f2_nxt     = f2_r;
    w1_nxt     = w1_r;
    w2_nxt     = w2_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    taken_nxt  = taken_r;
    k_nxt      = k_r;
    c_nxt      = c_r;
    len_nxt    = len_r;
    code_nxt   = code_r;
    symw_nxt   = symw_r;
    w_we       = 1'b0;
    w_waddr    = NW'(leaf_r);
    w_wdata    = leaf_w;
    p_we       = 1'b0;
    p_waddr    = a_r;
    p_wdata    = {next_r, 1'b0};

    if (cmd.load) begin
      if (leaf_r == '0) begin
        taken_nxt = '0;
      end
      if (leaf_r < CW'(MAX_SYMBOLS)) begin
        w_we     = 1'b1;
        leaf_nxt = leaf_r + CW'(1);
      end
      next_nxt = NW'(leaf_nxt);
    end

    if (cmd.scan_start) begin
      i_nxt  = '0;
      f1_nxt = 1'b0;
      f2_nxt = 1'b0;
    end

    if (cmd.scan_step) begin
      if (i_r != next_r) begin
        rd_vld_nxt = 1'b1;
        i_nxt      = i_r + NW'(1);
      end
      if (rd_vld_r && !taken_r[rd_idx_r]) begin
        if (!f1_r || w_rdata < w1_r) begin
          f2_nxt = f1_r;
          w2_nxt = w1_r;
          b_nxt  = a_r;
          f1_nxt = 1'b1;
          w1_nxt = w_rdata;
          a_nxt  = rd_idx_r;
        end else if (!f2_r || w_rdata < w2_r) begin
          f2_nxt = 1'b1;
          w2_nxt = w_rdata;
          b_nxt  = rd_idx_r;
        end
      end
    end

    if (cmd.merge_a) begin
      w_we             = 1'b1;
      w_waddr          = next_r;
      w_wdata          = w1_r + w2_r;
      p_we             = 1'b1;
      taken_nxt[a_r]   = 1'b1;
      taken_nxt[b_r]   = 1'b1;
      taken_nxt[next_r] = 1'b0;
    end

    if (cmd.merge_b) begin
      p_we     = 1'b1;
      p_waddr  = b_r;
      p_wdata  = {next_r, 1'b1};
      next_nxt = next_r + NW'(1);
    end

    if (cmd.walk_init) begin
      c_nxt    = NW'(k_r);
      len_nxt  = '0;
      code_nxt = '0;
    end

    if (cmd.next_sym) begin
      k_nxt    = k_inc;
      c_nxt    = NW'(k_inc);
      len_nxt  = '0;
      code_nxt = '0;
    end

    if (cmd.wlatch) begin
      symw_nxt = w_rdata;
    end

    if (cmd.walk_up) begin
      if (p_rdata[0] && len_r < LW'(15)) begin
        code_nxt = code_r | (15'(1) << len_r);
      end
      len_nxt = len_r + LW'(1);
      c_nxt   = p_rdata[NW:1];
    end

    if (cmd.finish) begin
      leaf_nxt = '0;
      k_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_r   <= '0;
      k_r      <= '0;
      taken_r  <= '0;
      rd_vld_r <= 1'b0;
      f1_r     <= 1'b0;
      f2_r     <= 1'b0;
    end else begin
      leaf_r   <= leaf_nxt;
      k_r      <= k_nxt;
      taken_r  <= taken_nxt;
      rd_vld_r <= rd_vld_nxt;
      f1_r     <= f1_nxt;
      f2_r     <= f2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    next_r   <= next_nxt;
    i_r      <= i_nxt;
    rd_idx_r <= rd_idx_nxt;
    w1_r     <= w1_nxt;
    w2_r     <= w2_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    c_r      <= c_nxt;
    len_r    <= len_nxt;
    code_r   <= code_nxt;
    symw_r   <= symw_nxt;
  end

  assign sts.scan_done  = (i_r == next_r) && !rd_vld_r;
  assign sts.merge_pend = ((NW + 1)'(next_r) + (NW + 1)'(1)) < (NW + 1)'({leaf_r, 1'b0});
  assign sts.taken_c    = taken_r[c_r];
  assign sts.last_sym   = ((CW + 1)'(k_r) + (CW + 1)'(1)) == (CW + 1)'(leaf_r);

  assign symw_ext   = {16'b0, symw_r};
  assign k_ext      = {4'b0, k_r};
  assign sym_weight = symw_ext[15:0];
  assign sym_index  = k_ext[3:0];
  assign code_bits  = code_r;
  assign code_len   = len_r[3:0];

  a_merge_found : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_a |-> (f1_r && f2_r))
    else $error("merge without two free nodes");

  a_merge_distinct : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_a |-> (a_r != b_r))
    else $error("merge picked one node twice");

  a_sym_range : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.next_sym |-> !sts.last_sym)
    else $error("advance past final symbol");

endmodule
`default_nettype wire

@@ sv/hcb_ctrl.sv @@
`default_nettype none
module hcb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic          in_tlast,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output hcb_pkg::cmd_t      cmd,
  input  wire hcb_pkg::sts_t sts
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHK     = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_MRG_A   = 4'd3;
  localparam logic [3:0] S_MRG_B   = 4'd4;
  localparam logic [3:0] S_WALK_W  = 4'd5;
  localparam logic [3:0] S_WALK_RD = 4'd6;
  localparam logic [3:0] S_WALK_UP = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (sts.merge_pend) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK_W;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_MRG_A;
        end
      end
      S_MRG_A: begin
        cmd.merge_a = 1'b1;
        state_nxt   = S_MRG_B;
      end
      S_MRG_B: begin
        cmd.merge_b = 1'b1;
        state_nxt   = S_CHK;
      end
      S_WALK_W: begin
        cmd.wlatch = 1'b1;
        state_nxt  = S_WALK_RD;
      end
      S_WALK_RD: begin
        state_nxt = sts.taken_c ? S_WALK_UP : S_OUT;
      end
      S_WALK_UP: begin
        cmd.walk_up = 1'b1;
        state_nxt   = S_WALK_RD;
      end
      S_OUT: begin
        if (out_tready) begin
          if (sts.last_sym) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.next_sym = 1'b1;
            state_nxt    = S_WALK_W;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  a_load_idle : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_tready && in_tvalid))
    else $error("load outside an accepted request");

  a_merge_seq : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_a |=> cmd.merge_b)
    else $error("merge halves split");

  a_scan_end : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MRG_A) |-> $past(sts.scan_done))
    else $error("merge before scan finished");

endmodule
`default_nettype wire

@@ sv/huffman_code_builder.sv @@
// Huffman code builder.
// Input channel in_*: one symbol weight per request (in_tdata[15:0]); in_tlast
// marks the final weight of a set and starts the build. The first request of a
// set clears the node table; weights past MAX_SYMBOLS are dropped.
// Output channel out_*: one request per loaded symbol, in load order; out_tlast
// on the final symbol.
// Operation: the build runs n-1 merges. A merge that creates node m is one
// check state, a scan of nodes 0..m-1 through the weight RAM's single read
// port, and two write states (MRG_A, MRG_B). The build ends with one final
// check. Each code is then found by walking the parent RAM one level at a
// time, with a read state and a walk-up state per level.
// in_tready is high only while a set is being loaded (idle); no new set is taken until every code
// of the current set has been delivered. A stalled out_tready holds the code
// and all work. Reset returns the block to the start of a set.
`default_nettype none
module huffman_code_builder #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [hcb_pkg::IN_TDATA_W-1:0]  in_tdata,   // weight[15:0]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // symbol_index[3:0], symbol_weight[19:4], code_bits[34:20],
  // code_length[38:35], pad[39]
  output logic [hcb_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic             out_tlast
);

  hcb_pkg::cmd_t cmd;
  hcb_pkg::sts_t sts;
  logic [3:0]    sym_index;
  logic [15:0]   sym_weight;
  logic [14:0]   code_bits;
  logic [3:0]    code_len;

  hcb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cmd(cmd), .sts(sts)
  );

  hcb_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_weight(in_tdata),
    .sym_index(sym_index), .sym_weight(sym_weight),
    .code_bits(code_bits), .code_len(code_len)
  );

  assign out_tdata = {1'b0, code_len, code_bits, sym_weight, sym_index};
  assign out_tlast = sts.last_sym;

endmodule
`default_nettype wire

@@ tb/sv/huffman_code_builder_test.sv @@
module huffman_code_builder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSYM = 16;
  localparam int SLOTS = 2 * NSYM;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        last;
    logic [15:0] weight;
  } weight_req_t;

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] weight;
    logic [14:0] code;
    logic [3:0]  len;
    logic        last;
  } code_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [hcb_pkg::IN_TDATA_W-1:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [hcb_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;

  huffman_code_builder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  weight_req_t pending_q[$];
  code_res_t   code_q[$];
  int errors = 0;
  bit stim_done = 0;
  bit quiet = 0;
  bit hold_in = 0;
  int hold_out = 0;
  longint cycles = 0;

  logic [19:0] nw[SLOTS];
  logic [4:0]  nl[SLOTS];
  logic [4:0]  np[SLOTS];
  bit          nt[SLOTS];
  int          leaves = 0;

  function automatic int pick_min(int lim);
    int best;
    bit found;
    best = 0;
    found = 0;
    for (int i = 0; i < lim; i++)
      if (!nt[i] && (!found || nw[i] < nw[best])) begin
        best = i;
        found = 1;
      end
    nt[best] = 1;
    return best;
  endfunction

  task automatic predict_codes(weight_req_t r);
    int a, b, c, len;
    logic [14:0] code;
    code_res_t e;
    if (leaves == 0)
      for (int i = 0; i < SLOTS; i++) begin
        nw[i] = '0; nl[i] = '0; np[i] = '0; nt[i] = 0;
      end
    if (leaves < NSYM) begin
      nw[leaves] = r.weight;
      leaves++;
    end
    if (!r.last) return;
    for (int nx = leaves; nx + 1 < 2 * leaves; nx++) begin
      a = pick_min(nx);
      b = pick_min(nx);
      np[a] = nx; np[b] = nx; nl[nx] = a;
      nw[nx] = nw[a] + nw[b];
      nt[nx] = 0;
    end
    for (int k = 0; k < leaves; k++) begin
      code = '0;
      len = 0;
      c = k;
      for (int g = 0; g < SLOTS && nt[c]; g++) begin
        if (nl[np[c]] != c && len < 15) code[len] = 1'b1;
        len++;
        c = np[c];
      end
      e.idx = k;
      e.weight = nw[k][15:0];
      e.code = code;
      e.len = len;
      e.last = (k + 1 == leaves);
      code_q.push_back(e);
    end
    leaves = 0;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_codes(pending_q.pop_front());
      end
      if (in_gap > 0) in_gap--;
      if (in_tvalid && !in_tready) begin
      end else if (!hold_in && pending_q.size() > 0 && in_gap == 0 &&
                   (quiet || $urandom_range(0, 4) != 0)) begin
        in_tvalid <= 1;
        in_tdata <= pending_q[0].weight;
        in_tlast <= pending_q[0].last;
      end else begin
        in_tvalid <= 0;
        if (!quiet && in_gap == 0 && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 3);
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    code_res_t got, exp;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      cycles++;
      if (out_tvalid && out_tready) begin
        got.idx = out_tdata[3:0];
        got.weight = out_tdata[19:4];
        got.code = out_tdata[34:20];
        got.len = out_tdata[38:35];
        got.last = out_tlast;
        if (code_q.size() == 0) begin
          $display("%0t: unexpected code request %h", $time, got);
          errors++;
        end else begin
          exp = code_q.pop_front();
          if (got.idx !== exp.idx)
            $display("%0t: symbol_index exp %0d got %0d", $time, exp.idx, got.idx);
          if (got.weight !== exp.weight)
            $display("%0t: symbol_weight exp %0d got %0d", $time, exp.weight, got.weight);
          if (got.code !== exp.code)
            $display("%0t: code_bits exp %h got %h", $time, exp.code, got.code);
          if (got.len !== exp.len)
            $display("%0t: code_length exp %0d got %0d", $time, exp.len, got.len);
          if (got.last !== exp.last)
            $display("%0t: last_code exp %0d got %0d", $time, exp.last, got.last);
          if (got !== exp) errors++;
        end
      end
      if (hold_out > 0) begin
        hold_out--;
        out_tready <= 0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 2);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic add_set(int n, bit rnd, int fixed);
    weight_req_t r;
    for (int i = 0; i < n; i++) begin
      r.weight = rnd ? 16'($urandom) : 16'(fixed);
      r.last = (i == n - 1);
      pending_q.push_back(r);
    end
  endtask

  task automatic drain;
    while (pending_q.size() > 0 || in_tvalid || code_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    weight_req_t r;
    int n, m;
    in_tvalid = 0; in_tdata = '0; in_tlast = 0; out_tready = 0;
    rst_n = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // directed: single symbol, extremes, ties
    add_set(1, 0, 16'hffff);
    add_set(2, 0, 0);
    add_set(3, 0, 16'hffff);
    r = '{last: 0, weight: 16'h0001}; pending_q.push_back(r);
    r = '{last: 0, weight: 16'h0002}; pending_q.push_back(r);
    r = '{last: 0, weight: 16'h0004}; pending_q.push_back(r);
    r = '{last: 1, weight: 16'h8000}; pending_q.push_back(r);
    drain();
    // overflow: 18 weights, drops past 16, last dropped still builds
    for (int i = 0; i < 18; i++) begin
      r.weight = (i < 16) ? 16'(1 << (i % 16)) : 16'hffff;
      r.last = (i == 17);
      pending_q.push_back(r);
    end
    // sender pause until all results arrive
    drain();
    // long receiver stall
    hold_out = 300;
    add_set(16, 1, 0);
    add_set(4, 1, 0);
    drain();
    n = 0;
    while (n < 300) begin
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 18) : $urandom_range(1, 16);
      for (int i = 0; i < m; i++) begin
        case ($urandom_range(0, 3))
          0: r.weight = 16'($urandom_range(0, 3));
          1: r.weight = 16'hffff - 16'($urandom_range(0, 3));
          default: r.weight = 16'($urandom);
        endcase
        r.last = (i == m - 1);
        pending_q.push_back(r);
      end
      n += m;
      if (n > 240) quiet = 1;
      if (pending_q.size() > 40) drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (pending_q.size() > 0 || in_tvalid || code_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && code_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end
endmodule
